// ----- hdl/bvar_pkg.sv -----
package bvar_pkg;

  // Row geometry and field widths
  localparam int unsigned Lanes    = 4;
  localparam int unsigned PixW     = 12;
  localparam int unsigned DiffW    = 13;
  localparam int unsigned SqW      = 24;
  localparam int unsigned RowDiffW = 15;
  localparam int unsigned RowSqW   = 26;
  localparam int unsigned SseW     = 28;
  localparam int unsigned SumW     = 18;
  localparam int unsigned VarW     = 32;
  localparam int unsigned ProdW    = 2 * SumW;
  localparam int unsigned SqShift  = 4;

  // Configuration port
  localparam int unsigned AddrW      = 3;
  localparam int unsigned DataW      = 32;
  localparam int unsigned DepthW     = 2;
  localparam logic        RegDepthIdx = 1'b0;

  // Depth codes: bit 1 alone selects 12-bit rounding
  localparam logic [DepthW-1:0] Depth10   = 2'd1;
  localparam int unsigned       Depth12Bit = 1;

  // Rounding amounts
  localparam int SseHalf10 = 8;
  localparam int SseSh10   = 4;
  localparam int SseHalf12 = 128;
  localparam int SseSh12   = 8;
  localparam int SumHalf10 = 2;
  localparam int SumSh10   = 2;
  localparam int SumHalf12 = 8;
  localparam int SumSh12   = 4;

  localparam logic [1:0] LastRow = 2'd3;

  typedef struct packed {
    logic signed [DiffW-1:0] diff;
    logic [SqW-1:0]          sq;
  } bvar_lane_t;

  typedef struct packed {
    logic                   valid;
    logic [SseW-1:0]        sse;
    logic signed [SumW-1:0] sum;
  } bvar_blk_t;

endpackage

// ----- hdl/bvar_if.sv -----
interface bvar_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] src_pixel_0;
  logic [11:0] src_pixel_1;
  logic [11:0] src_pixel_2;
  logic [11:0] src_pixel_3;
  logic [11:0] ref_pixel_0;
  logic [11:0] ref_pixel_1;
  logic [11:0] ref_pixel_2;
  logic [11:0] ref_pixel_3;

  modport source (
    output valid, src_pixel_0, src_pixel_1, src_pixel_2, src_pixel_3,
    output ref_pixel_0, ref_pixel_1, ref_pixel_2, ref_pixel_3,
    input  ready
  );
  modport sink (
    input  valid, src_pixel_0, src_pixel_1, src_pixel_2, src_pixel_3,
    input  ref_pixel_0, ref_pixel_1, ref_pixel_2, ref_pixel_3,
    output ready
  );
endinterface

interface bvar_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] block_sse;
  logic [31:0] block_variance;

  modport source (output valid, block_sse, block_variance, input ready);
  modport sink (input valid, block_sse, block_variance, output ready);
endinterface

// ----- hdl/bvar_lane.sv -----
module bvar_lane (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [bvar_pkg::PixW-1:0]       src_i,
  input  logic [bvar_pkg::PixW-1:0]       ref_i,
  output bvar_pkg::bvar_lane_t            lane_o
);
  import bvar_pkg::*;

  logic signed [DiffW-1:0]   diff;
  logic signed [2*DiffW-1:0] sq_full;
  bvar_lane_t                lane_d, lane_q;

  // Difference and its square for one column
  always_comb begin
    diff        = signed'({1'b0, src_i}) - signed'({1'b0, ref_i});
    sq_full     = diff * diff;
    lane_d.diff = diff;
    lane_d.sq   = sq_full[SqW-1:0];
  end

  // Hold while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ----- hdl/bvar_merge.sv -----
module bvar_merge (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [bvar_pkg::DepthW-1:0]     depth_i,
  input  bvar_pkg::bvar_lane_t            lanes_i [bvar_pkg::Lanes],
  output bvar_pkg::bvar_blk_t             blk_o
);
  import bvar_pkg::*;

  logic signed [RowDiffW-1:0] row_diff_d, row_diff_q;
  logic [RowSqW-1:0]          row_sq_d, row_sq_q;
  logic                       row_v_q;

  logic [1:0]                 row_cnt_q;
  logic signed [SumW-1:0]     diff_acc_q;
  logic [SseW-1:0]            sq_acc_q;

  logic signed [SumW-1:0]     tot_diff;
  logic [SseW-1:0]            tot_sq;
  logic [SseW:0]              sse_ext;
  logic signed [SumW:0]       sum_ext;
  logic                       last_row;
  bvar_blk_t                  blk_d, blk_q;

  // Combine the lanes of one row
  always_comb begin
    row_diff_d = '0;
    row_sq_d   = '0;
    for (int i = 0; i < Lanes; i++) begin
      row_diff_d = row_diff_d + RowDiffW'(lanes_i[i].diff);
      row_sq_d   = row_sq_d + RowSqW'(lanes_i[i].sq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_v_q <= 1'b0;
    end else if (en_i) begin
      row_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_diff_q <= row_diff_d;
      row_sq_q   <= row_sq_d;
    end
  end

  // Block totals including the current row, then depth rounding
  always_comb begin
    tot_diff = diff_acc_q + SumW'(row_diff_q);
    tot_sq   = sq_acc_q + SseW'(row_sq_q);
    last_row = row_v_q && (row_cnt_q == LastRow);
    sse_ext  = {1'b0, tot_sq};
    sum_ext  = (SumW + 1)'(tot_diff);

    blk_d.valid = last_row;
    if (depth_i[Depth12Bit]) begin
      blk_d.sse = SseW'((sse_ext + (SseW + 1)'(SseHalf12)) >> SseSh12);
      blk_d.sum = SumW'((sum_ext + (SumW + 1)'(SumHalf12)) >>> SumSh12);
    end else if (depth_i == Depth10) begin
      blk_d.sse = SseW'((sse_ext + (SseW + 1)'(SseHalf10)) >> SseSh10);
      blk_d.sum = SumW'((sum_ext + (SumW + 1)'(SumHalf10)) >>> SumSh10);
    end else begin
      blk_d.sse = tot_sq;
      blk_d.sum = tot_diff;
    end
  end

  // Advance the row count and sums; clear them after the fourth row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q  <= '0;
      diff_acc_q <= '0;
      sq_acc_q   <= '0;
      blk_q      <= '0;
    end else if (en_i) begin
      blk_q <= blk_d;
      if (row_v_q) begin
        if (last_row) begin
          row_cnt_q  <= '0;
          diff_acc_q <= '0;
          sq_acc_q   <= '0;
        end else begin
          row_cnt_q  <= row_cnt_q + 2'd1;
          diff_acc_q <= tot_diff;
          sq_acc_q   <= tot_sq;
        end
      end
    end
  end

  assign blk_o = blk_q;

  a_last_row_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && last_row) |=> blk_q.valid)
    else $error("fourth row did not produce a block result");

  a_no_early_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && !last_row) |=> !blk_q.valid)
    else $error("block result without a fourth row");

  a_count_advances : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && row_v_q) |=> (row_cnt_q == $past(row_cnt_q) + 2'd1))
    else $error("row count did not advance on an accepted row");

endmodule

// ----- hdl/bvar_finish.sv -----
module bvar_finish (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  bvar_pkg::bvar_blk_t         blk_i,
  output logic                        out_valid_o,
  output logic [bvar_pkg::SseW-1:0]   sse_o,
  output logic [bvar_pkg::VarW-1:0]   var_o
);
  import bvar_pkg::*;

  logic signed [ProdW-1:0] prod_d;
  logic [ProdW-1:0]        prod_q;
  logic [SseW-1:0]         sse_q;
  logic                    prod_v_q;
  logic [VarW-1:0]         var_d;
  logic                    out_valid_q;
  logic [SseW-1:0]         out_sse_q;
  logic [VarW-1:0]         out_var_q;

  // Square the rounded sum
  assign prod_d = blk_i.sum * blk_i.sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
    end else if (en_i) begin
      prod_v_q <= blk_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(prod_d);
      sse_q  <= blk_i.sse;
    end
  end

  // Variance wraps modulo 2^32
  assign var_d = VarW'(sse_q) - prod_q[ProdW-1:SqShift];

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= prod_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_sse_q <= sse_q;
      out_var_q <= var_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sse_o       = out_sse_q;
  assign var_o       = out_var_q;

  a_prod_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && blk_i.valid) |=> prod_v_q)
    else $error("square stage lost a block");

  a_out_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && prod_v_q) |=> out_valid_q)
    else $error("output register lost a block");

  a_var_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && prod_v_q) |=> (out_var_q == $past(var_d)))
    else $error("variance not captured from the square stage");

endmodule

// ----- hdl/block_variance_4x4_highbd.sv -----
// Channel  Role    Handshake      Payload
// in_if    sink    valid/ready    one row: src_pixel_0..3, ref_pixel_0..3
// out_if   source  valid/ready    block_sse, block_variance
// apb      slave   psel/penable   bit_depth_mode at addresses 0 to 3
//
// One row is accepted per cycle unless the output stalls; the four column lanes take a
// whole row at once. A result passes lane, row, block, square and output registers.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset clears the row count, both sums and the depth register to 8-bit.
module block_variance_4x4_highbd (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bvar_in_if.sink                       in_if,
  bvar_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bvar_pkg::AddrW-1:0]    paddr,
  input  logic [bvar_pkg::DataW-1:0]    pwdata,
  output logic [bvar_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import bvar_pkg::*;

  logic [DepthW-1:0] depth_q;
  logic              en;
  logic              row_v_q;
  logic              out_valid;
  logic [PixW-1:0]   src_px [Lanes];
  logic [PixW-1:0]   ref_px [Lanes];
  bvar_lane_t        lanes [Lanes];
  bvar_blk_t         blk;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else if (psel && penable && pwrite && (paddr[AddrW-1] == RegDepthIdx)) begin
      depth_q <= pwdata[DepthW-1:0];
    end
  end

  assign prdata = (paddr[AddrW-1] == RegDepthIdx) ? DataW'(depth_q) : '0;
  assign pready = 1'b1;

  // Advance whenever the output register can move
  assign en          = !out_valid || out_if.ready;
  assign in_if.ready = en;

  always_comb begin
    src_px[0] = in_if.src_pixel_0;
    src_px[1] = in_if.src_pixel_1;
    src_px[2] = in_if.src_pixel_2;
    src_px[3] = in_if.src_pixel_3;
    ref_px[0] = in_if.ref_pixel_0;
    ref_px[1] = in_if.ref_pixel_1;
    ref_px[2] = in_if.ref_pixel_2;
    ref_px[3] = in_if.ref_pixel_3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_v_q <= 1'b0;
    end else if (en) begin
      row_v_q <= in_if.valid;
    end
  end

  // One lane per column
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    bvar_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .src_i  (src_px[g]),
      .ref_i  (ref_px[g]),
      .lane_o (lanes[g])
    );
  end

  bvar_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (row_v_q),
    .depth_i (depth_q),
    .lanes_i (lanes),
    .blk_o   (blk)
  );

  bvar_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .blk_i       (blk),
    .out_valid_o (out_valid),
    .sse_o       (out_if.block_sse),
    .var_o       (out_if.block_variance)
  );

  assign out_if.valid = out_valid;

endmodule
